FILE: design/assert_macros.svh
// Assertion macros for the RTL, used by kmw_datapath.
// Depends on nothing; simulation builds see the checks, SYNTH builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KMW_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("KMW_ASSERT_ALWAYS failed");
`define KMW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("KMW_ASSERT_IMPLY failed");
`else
`define KMW_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define KMW_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/kmw_pkg.sv
// Package for the Kruskal spanning-forest block: default sizes and the
// command / status structs between controller and datapath. No dependencies.
`default_nettype none
package kmw_pkg;
    localparam int KMW_MAX_NODES = 256;
    localparam int KMW_MAX_EDGES = 4096;
    localparam int KMW_NC_W      = 9;   // node_count register width
    localparam int KMW_TOTAL_W   = 40;
    localparam int KMW_TAKEN_W   = 8;

    typedef struct packed {
        logic load;
        logic start;
        logic init_wr;
        logic pass_begin;
        logic run_begin;
        logic run_end;
        logic merge;
        logic edge_begin;
        logic edge_take;
        logic edge_skip;
        logic edge_next;
        logic find_ck;
        logic cmp_done;
        logic cmp_wr;
        logic unite;
        logic finish;
        logic sel_b;
    } t_cmd;

    typedef struct packed {
        logic width_lt_cnt;
        logic lo_lt_cnt;
        logic node_last;
        logic merge_last;
        logic edge_end;
        logic stop;
        logic out_range;
        logic is_root;
        logic x_at_root;
        logic same_set;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

FILE: design/kmw_if.sv
// Channel interfaces: edge items in, result items out.
// Valid/ready handshake; no dependencies.
`default_nettype none
interface kmw_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  end_a;
    logic [7:0]  end_b;
    logic [31:0] weight;
    logic        last;
    modport source (output valid, end_a, end_b, weight, last, input ready);
    modport sink   (input valid, end_a, end_b, weight, last, output ready);
endinterface

interface kmw_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] total_weight;
    logic [7:0]  edges_taken;
    logic        dropped;
    modport source (output valid, total_weight, edges_taken, dropped, input ready);
    modport sink   (input valid, total_weight, edges_taken, dropped, output ready);
endinterface
`default_nettype wire

FILE: design/kruskal_mst_weight.sv
// Kruskal spanning forest: edges load at one transfer per cycle while idle.
// The last edge starts: set init of every node slot, then merge-sort passes
// (ceil(log2(E)) passes) that read and merge each element of every run,
// then a union-find walk with a read and a check per parent hop for each
// edge; one result transfer follows, held while the receiver stalls.
// Sync active-low reset: idle, store empty, node_count 1, no result pending.
`default_nettype none
module kruskal_mst_weight
    import kmw_pkg::*;
#(
    parameter int MAX_NODES = KMW_MAX_NODES,
    parameter int MAX_EDGES = KMW_MAX_EDGES
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [KMW_NC_W-1:0] i_cfg_wdata,
    kmw_in_if.sink                   i_edge,
    kmw_out_if.source                o_result
);
    t_cmd cmd;
    t_sts sts;

    // controller: owns the handshake on the edge channel and sequencing
    kmw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_edge.valid),
        .i_in_last  (i_edge.last),
        .o_in_ready (i_edge.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: memories, cursors and the result register
    kmw_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_end_a        (i_edge.end_a),
        .i_end_b        (i_edge.end_b),
        .i_weight       (i_edge.weight),
        .o_valid        (o_result.valid),
        .i_ready        (o_result.ready),
        .o_total_weight (o_result.total_weight),
        .o_edges_taken  (o_result.edges_taken),
        .o_dropped      (o_result.dropped)
    );
endmodule
`default_nettype wire

FILE: design/kmw_ctrl.sv
// Controller FSM: load, set init, merge-sort passes, union-find walk, result.
// Depends on kmw_pkg.
`default_nettype none
module kmw_ctrl
    import kmw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_last,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);
    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_INIT   = 15'h0002,
        S_PASS   = 15'h0004,
        S_RUN    = 15'h0008,
        S_RD     = 15'h0010,
        S_MRG    = 15'h0020,
        S_EDGE   = 15'h0040,
        S_ECHK   = 15'h0080,
        S_FND_RD = 15'h0100,
        S_FND_CK = 15'h0200,
        S_CMP_RD = 15'h0400,
        S_CMP_WR = 15'h0800,
        S_SZ_RD  = 15'h1000,
        S_UNION  = 15'h2000,
        S_FIN    = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_opb, n_opb;
    logic   acc;

    assign o_in_ready = (r_state == S_IDLE);
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_opb   = r_opb;
        o_cmd   = '0;
        o_cmd.sel_b = r_opb;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = acc;
                if (acc && i_in_last) begin
                    o_cmd.start = 1'b1;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init_wr = 1'b1;
                if (i_sts.node_last) n_state = S_PASS;
            end
            S_PASS: begin
                if (i_sts.width_lt_cnt) begin
                    o_cmd.pass_begin = 1'b1;
                    n_state = S_RUN;
                end else begin
                    o_cmd.edge_begin = 1'b1;
                    n_state = S_EDGE;
                end
            end
            S_RUN: begin
                if (i_sts.lo_lt_cnt) begin
                    o_cmd.run_begin = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.run_end = 1'b1;
                    n_state = S_PASS;
                end
            end
            S_RD: n_state = S_MRG;
            S_MRG: begin
                o_cmd.merge = 1'b1;
                n_state = i_sts.merge_last ? S_RUN : S_RD;
            end
            S_EDGE: n_state = i_sts.edge_end ? S_FIN : S_ECHK;
            S_ECHK: begin
                priority if (i_sts.stop) begin
                    n_state = S_FIN;
                end else if (i_sts.out_range) begin
                    o_cmd.edge_skip = 1'b1;
                    n_state = S_EDGE;
                end else begin
                    o_cmd.edge_take = 1'b1;
                    n_opb   = 1'b0;
                    n_state = S_FND_RD;
                end
            end
            S_FND_RD: n_state = S_FND_CK;
            S_FND_CK: begin
                o_cmd.find_ck = 1'b1;
                n_state = i_sts.is_root ? S_CMP_RD : S_FND_RD;
            end
            S_CMP_RD: begin
                if (i_sts.x_at_root) begin
                    o_cmd.cmp_done = 1'b1;
                    if (!r_opb) begin
                        n_opb   = 1'b1;
                        n_state = S_FND_RD;
                    end else begin
                        n_state = S_SZ_RD;
                    end
                end else begin
                    n_state = S_CMP_WR;
                end
            end
            S_CMP_WR: begin
                o_cmd.cmp_wr = 1'b1;
                n_state = S_CMP_RD;
            end
            S_SZ_RD: begin
                if (i_sts.same_set) begin
                    o_cmd.edge_next = 1'b1;
                    n_state = S_EDGE;
                end else begin
                    n_state = S_UNION;
                end
            end
            S_UNION: begin
                o_cmd.unite = 1'b1;
                n_state = S_EDGE;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_opb   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_opb   <= n_opb;
        end
    end
endmodule
`default_nettype wire

FILE: design/kmw_datapath.sv
// Datapath: edge store and sort buffer, parent and set-size memories,
// merge cursors, union-find registers, result register. Depends on kmw_pkg.
`default_nettype none
`include "assert_macros.svh"
module kmw_datapath
    import kmw_pkg::*;
#(
    parameter int MAX_NODES = KMW_MAX_NODES,
    parameter int MAX_EDGES = KMW_MAX_EDGES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_cfg_we,
    input  wire logic [KMW_NC_W-1:0]   i_cfg_wdata,
    input  wire logic [7:0]            i_end_a,
    input  wire logic [7:0]            i_end_b,
    input  wire logic [31:0]           i_weight,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [KMW_TOTAL_W-1:0]     o_total_weight,
    output logic [KMW_TAKEN_W-1:0]     o_edges_taken,
    output logic                       o_dropped
);
    localparam int CW  = $clog2(MAX_EDGES + 1);
    localparam int IW  = CW + 2;
    localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int NW  = $clog2(MAX_NODES);
    localparam int SW  = $clog2(MAX_NODES + 1);
    localparam int NCM = $clog2(MAX_NODES + 1);
    localparam int NCW = (NCM > KMW_NC_W) ? NCM : KMW_NC_W;

    logic [47:0] mem0 [MAX_EDGES];
    logic [47:0] mem1 [MAX_EDGES];
    logic [NW-1:0] par_mem [MAX_NODES];
    logic [SW-1:0] sz_mem  [MAX_NODES];

    logic [KMW_NC_W-1:0] r_node_count;
    logic [CW-1:0]  r_cnt;
    logic           r_drop;
    logic           r_src;
    logic [IW-1:0]  r_width, r_lo, r_mid, r_hi, r_i, r_j, r_k;
    logic [NW-1:0]  r_node;
    logic [47:0]    r_m0_i, r_m0_j, r_m1_i, r_m1_j;
    logic [47:0]    r_edge;
    logic [NW-1:0]  r_x, r_root, r_ra, r_par;
    logic [SW-1:0]  r_sz_a, r_sz_b;
    logic [KMW_TOTAL_W-1:0] r_total;
    logic [NCW-1:0] r_taken;
    logic           r_o_valid;
    logic [KMW_TOTAL_W-1:0] r_o_total;
    logic [KMW_TAKEN_W-1:0] r_o_taken;
    logic           r_o_drop;

    logic [NCW-1:0] n_use;
    logic [IW-1:0]  cnt_w, lo_w1, lo_w2, mid_nx, hi_nx;
    logic [47:0]    d_i, d_j, wr_data;
    logic           take_i, bad_in;
    logic [NW-1:0]  ea, eb, child_root, big;
    logic [SW-1:0]  sz_sum;

    // nodes in use, clipped to the configured maximum
    assign n_use = (NCW'(r_node_count) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                          : NCW'(r_node_count);
    assign cnt_w  = IW'(r_cnt);
    assign lo_w1  = r_lo + r_width;
    assign lo_w2  = r_lo + (r_width << 1);
    assign mid_nx = (lo_w1 < cnt_w) ? lo_w1 : cnt_w;
    assign hi_nx  = (lo_w2 < cnt_w) ? lo_w2 : cnt_w;

    assign d_i = r_src ? r_m1_i : r_m0_i;
    assign d_j = r_src ? r_m1_j : r_m0_j;
    assign take_i  = (r_i < r_mid) && ((r_j >= r_hi) || !(d_j < d_i));
    assign wr_data = take_i ? d_i : d_j;

    assign bad_in = (NCW'(i_end_a) >= n_use) || (NCW'(i_end_b) >= n_use)
                 || (r_cnt >= CW'(MAX_EDGES));

    assign ea = NW'(r_edge[15:8]);
    assign eb = NW'(r_edge[7:0]);
    assign child_root = (r_sz_a < r_sz_b) ? r_ra : r_root;
    assign big        = (r_sz_a < r_sz_b) ? r_root : r_ra;
    assign sz_sum     = r_sz_a + r_sz_b;

    always_comb begin
        o_sts = '0;
        o_sts.width_lt_cnt = r_width < cnt_w;
        o_sts.lo_lt_cnt    = r_lo < cnt_w;
        o_sts.node_last    = (r_node == NW'(MAX_NODES - 1));
        o_sts.merge_last   = (IW'(r_k + 1'b1) == r_hi);
        o_sts.edge_end     = r_i >= cnt_w;
        o_sts.stop         = (n_use == '0) || (r_taken == n_use - 1'b1);
        o_sts.out_range    = (NCW'(d_i[15:8]) >= n_use) || (NCW'(d_i[7:0]) >= n_use);
        o_sts.is_root      = (r_par == r_x);
        o_sts.x_at_root    = (r_x == r_root);
        o_sts.same_set     = (r_ra == r_root);
        o_sts.out_busy     = r_o_valid && !i_ready;
    end

    // edge store (mem0) and sort buffer (mem1); two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !bad_in)
            mem0[r_cnt[AW-1:0]] <= {i_weight, i_end_a, i_end_b};
        else if (i_cmd.merge && r_src)
            mem0[r_k[AW-1:0]] <= wr_data;
        if (i_cmd.merge && !r_src)
            mem1[r_k[AW-1:0]] <= wr_data;
        r_m0_i <= mem0[r_i[AW-1:0]];
        r_m0_j <= mem0[r_j[AW-1:0]];
        r_m1_i <= mem1[r_i[AW-1:0]];
        r_m1_j <= mem1[r_j[AW-1:0]];
    end

    // parent and set-size memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_wr)
            par_mem[r_node] <= r_node;
        else if (i_cmd.cmp_wr)
            par_mem[r_x] <= r_root;
        else if (i_cmd.unite)
            par_mem[child_root] <= big;
        if (i_cmd.init_wr)
            sz_mem[r_node] <= SW'(1);
        else if (i_cmd.unite)
            sz_mem[big] <= sz_sum;
        r_par  <= par_mem[r_x];
        r_sz_a <= sz_mem[r_ra];
        r_sz_b <= sz_mem[r_root];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= KMW_NC_W'(1);
            r_cnt        <= '0;
            r_drop       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) r_node_count <= i_cfg_wdata;
            if (i_cmd.load) begin
                if (bad_in) r_drop <= 1'b1;
                else        r_cnt  <= r_cnt + 1'b1;
            end
            if (i_cmd.edge_skip) r_drop <= 1'b1;
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
                r_cnt     <= '0;
                r_drop    <= 1'b0;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // sort cursors and union-find working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_src   <= 1'b0;
            r_width <= IW'(1);
            r_node  <= '0;
            r_total <= '0;
            r_taken <= '0;
        end
        if (i_cmd.init_wr) r_node <= r_node + 1'b1;
        if (i_cmd.pass_begin) r_lo <= '0;
        if (i_cmd.run_begin) begin
            r_mid <= mid_nx;
            r_hi  <= hi_nx;
            r_i   <= r_lo;
            r_j   <= mid_nx;
            r_k   <= r_lo;
        end
        if (i_cmd.run_end) begin
            r_width <= r_width << 1;
            r_src   <= !r_src;
        end
        if (i_cmd.merge) begin
            r_k <= r_k + 1'b1;
            if (take_i) r_i <= r_i + 1'b1;
            else        r_j <= r_j + 1'b1;
            if (o_sts.merge_last) r_lo <= lo_w2;
        end
        if (i_cmd.edge_begin) r_i <= '0;
        if (i_cmd.edge_skip || i_cmd.edge_next) r_i <= r_i + 1'b1;
        if (i_cmd.edge_take) begin
            r_edge <= d_i;
            r_x    <= NW'(d_i[15:8]);
        end
        if (i_cmd.find_ck) begin
            if (o_sts.is_root) begin
                r_root <= r_x;
                r_x    <= i_cmd.sel_b ? eb : ea;
            end else begin
                r_x <= r_par;
            end
        end
        if (i_cmd.cmp_done && !i_cmd.sel_b) begin
            r_ra <= r_root;
            r_x  <= eb;
        end
        if (i_cmd.cmp_wr) r_x <= r_par;
        if (i_cmd.unite) begin
            r_total <= r_total + KMW_TOTAL_W'(r_edge[47:16]);
            r_taken <= r_taken + 1'b1;
            r_i     <= r_i + 1'b1;
        end
        if (i_cmd.finish) begin
            r_o_total <= r_total;
            r_o_taken <= KMW_TAKEN_W'(r_taken);
            r_o_drop  <= r_drop;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_total_weight = r_o_total;
    assign o_edges_taken  = r_o_taken;
    assign o_dropped      = r_o_drop;

    `KMW_ASSERT_ALWAYS(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(MAX_EDGES))
    `KMW_ASSERT_IMPLY(a_merge_in_run, i_clk, i_rst_n, i_cmd.merge, r_k < r_hi)
    `KMW_ASSERT_IMPLY(a_unite_distinct, i_clk, i_rst_n, i_cmd.unite, r_ra != r_root)
endmodule
`default_nettype wire

FILE: tb/sv/kruskal_mst_weight_test.sv
// Testbench for kruskal_mst_weight: edge batches with random gaps and stalls.
// Checks each result against a spanning-forest predictor in the bench.
// Depends on kmw_pkg, kmw_in_if / kmw_out_if and the kruskal_mst_weight RTL.
`timescale 1ns / 1ps
module kruskal_mst_weight_test;
    import kmw_pkg::*;

    localparam int N_CAP = KMW_MAX_NODES;
    localparam int E_CAP = KMW_MAX_EDGES;

    typedef struct {
        logic [7:0]  end_a;
        logic [7:0]  end_b;
        logic [31:0] weight;
        logic        last;
    } t_edge_item;

    typedef struct {
        logic [KMW_TOTAL_W-1:0] total_weight;
        logic [KMW_TAKEN_W-1:0] edges_taken;
        logic                   dropped;
    } t_forest_sum;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [KMW_NC_W-1:0] i_cfg_wdata = '0;

    kmw_in_if  edge_if ();
    kmw_out_if result_if ();

    kruskal_mst_weight u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_edge     (edge_if.sink),
        .o_result   (result_if.source)
    );

    always #6 i_clk = ~i_clk;

    // stimulus and expected-result stores
    t_edge_item  edge_queue[$];
    t_forest_sum forest_expected[$];

    // bench copy of the block state
    logic [KMW_NC_W-1:0] node_count_q = KMW_NC_W'(1);
    logic [47:0]         batch_edges[$];   // {weight, end_a, end_b}
    logic                batch_dropped = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_cnt = 0;
    int accepted_cnt = 0;
    int results_seen = 0;
    int batch_cnt = 0;
    int mismatch_cnt = 0;
    int items_pushed = 0;

    initial begin
        edge_if.valid = 1'b0;
        edge_if.end_a = '0;
        edge_if.end_b = '0;
        edge_if.weight = '0;
        edge_if.last = 1'b0;
        result_if.ready = 1'b0;
    end

    // Kruskal over the stored batch; sorting the packed words gives the
    // weight, end_a, end_b tie order. Path compression does not affect the sum.
    function automatic t_forest_sum span_forest();
        t_forest_sum res;
        logic [8:0]  root[N_CAP];
        logic [8:0]  members[N_CAP];
        logic [47:0] sorted[$];
        int n, ea, eb, ra, rb;
        res.total_weight = '0;
        res.edges_taken = '0;
        res.dropped = batch_dropped;
        n = (int'(node_count_q) > N_CAP) ? N_CAP : int'(node_count_q);
        for (int i = 0; i < N_CAP; i++) begin
            root[i] = 9'(i);
            members[i] = 9'd1;
        end
        sorted = batch_edges;
        sorted.sort();
        foreach (sorted[i]) begin
            ea = int'(sorted[i][15:8]);
            eb = int'(sorted[i][7:0]);
            if (n == 0 || int'(res.edges_taken) == n - 1) break;
            if (ea >= n || eb >= n) begin
                res.dropped = 1'b1;   // endpoint outside a lowered node count
                continue;
            end
            ra = ea;
            while (int'(root[ra]) != ra) ra = int'(root[ra]);
            rb = eb;
            while (int'(root[rb]) != rb) rb = int'(root[rb]);
            if (ra != rb) begin
                if (members[ra] < members[rb]) begin
                    root[ra] = 9'(rb);
                    members[rb] += members[ra];
                end else begin
                    root[rb] = 9'(ra);
                    members[ra] += members[rb];
                end
                res.total_weight += KMW_TOTAL_W'(sorted[i][47:16]);
                res.edges_taken++;
            end
        end
        return res;
    endfunction

    // Driver: changes at the falling edge; a transfer is seen when the
    // monitor count catches up with what was sent.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!edge_if.valid || accepted_cnt == sent_cnt) begin
                if (edge_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    edge_if.end_a  <= edge_queue[0].end_a;
                    edge_if.end_b  <= edge_queue[0].end_b;
                    edge_if.weight <= edge_queue[0].weight;
                    edge_if.last   <= edge_queue[0].last;
                    edge_if.valid  <= 1'b1;
                    void'(edge_queue.pop_front());
                    sent_cnt <= sent_cnt + 1;
                end else begin
                    edge_if.valid <= 1'b0;
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: input transfers feed the predictor, result transfers are checked.
    always @(posedge i_clk) begin
        int n;
        t_forest_sum got, want;
        if (i_rst_n && edge_if.valid && edge_if.ready) begin
            accepted_cnt <= accepted_cnt + 1;
            n = (int'(node_count_q) > N_CAP) ? N_CAP : int'(node_count_q);
            if (int'(edge_if.end_a) >= n || int'(edge_if.end_b) >= n ||
                batch_edges.size() >= E_CAP)
                batch_dropped = 1'b1;
            else
                batch_edges.insert(batch_edges.size(),
                                   {edge_if.weight, edge_if.end_a, edge_if.end_b});
            if (edge_if.last) begin
                forest_expected.insert(forest_expected.size(), span_forest());
                batch_edges.delete();
                batch_dropped = 1'b0;
            end
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.total_weight = result_if.total_weight;
            got.edges_taken  = result_if.edges_taken;
            got.dropped      = result_if.dropped;
            results_seen <= results_seen + 1;
            if (forest_expected.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("ERROR: unexpected result w=%0d n=%0d d=%0b",
                             got.total_weight, got.edges_taken, got.dropped);
            end else begin
                want = forest_expected.pop_front();
                if (got.total_weight !== want.total_weight ||
                    got.edges_taken !== want.edges_taken || got.dropped !== want.dropped) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("ERROR: result exp w=%0d n=%0d d=%0b got w=%0d n=%0d d=%0b",
                                 want.total_weight, want.edges_taken, want.dropped,
                                 got.total_weight, got.edges_taken, got.dropped);
                end
            end
        end
    end

    task automatic add_edge(input int a, input int b, input logic [31:0] w, input bit lst);
        t_edge_item it;
        it.end_a = 8'(a);
        it.end_b = 8'(b);
        it.weight = w;
        it.last = lst;
        edge_queue.insert(edge_queue.size(), it);
        items_pushed++;
        if (lst) batch_cnt++;
    endtask

    // wait for every transfer and result, then a short settle for a batch
    // that is still loading
    task automatic drain();
        while (edge_queue.size() > 0 || accepted_cnt != sent_cnt || forest_expected.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_node_count(input logic [KMW_NC_W-1:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        node_count_q = val;   // takes effect at the next rising edge, block idle
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        unique case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    initial begin
        int nc, len, lim;
        int nc_pick[8] = '{1, 2, 3, 8, 40, 256, 300, 511};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default node count 1, extreme fields, self loop
        add_edge(0, 0, 32'hFFFF_FFFF, 1'b1);
        add_edge(0, 1, 5, 1'b1);                          // out of range at one node
        write_node_count(KMW_NC_W'(256));
        add_edge(255, 0, 32'hFFFF_FFFF, 1'b0);
        add_edge(0, 255, 32'hFFFF_FFFF, 1'b0);            // tie broken on endpoints
        add_edge(7, 7, 0, 1'b0);                          // self loop
        add_edge(1, 2, 0, 1'b0);
        add_edge(2, 1, 0, 1'b1);
        write_node_count(KMW_NC_W'(0));                   // every edge out of range
        add_edge(0, 0, 1, 1'b1);
        write_node_count(KMW_NC_W'(511));                 // acts as the node cap
        add_edge(255, 254, 32'h8000_0000, 1'b0);
        add_edge(170, 85, 32'h5555_5555, 1'b1);
        // node count lowered with edges already loaded
        write_node_count(KMW_NC_W'(10));
        add_edge(9, 8, 3, 1'b0);
        add_edge(0, 1, 4, 1'b0);
        add_edge(2, 3, 1, 1'b0);
        write_node_count(KMW_NC_W'(4));
        add_edge(1, 2, 2, 1'b0);
        add_edge(0, 3, 9, 1'b1);
        // edges that all fit exactly, heavy weights so the sum exceeds 32 bits
        write_node_count(KMW_NC_W'(3));
        add_edge(0, 1, 32'hFFFF_FFFF, 1'b0);
        add_edge(1, 2, 32'hFFFF_FFFF, 1'b0);
        add_edge(0, 2, 32'hFFFF_FFFE, 1'b1);

        // random batches, mostly well formed, some out of range and ties
        while (items_pushed < 600) begin
            if (batch_cnt % 3 == 0) begin
                write_node_count(KMW_NC_W'(nc_pick[$urandom_range(7)]));
                set_idling(batch_cnt / 6);
            end
            nc = (int'(node_count_q) > N_CAP) ? N_CAP : int'(node_count_q);
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
                lim = (nc == 0) ? 0 : nc - 1;
                if ($urandom_range(9) == 0)
                    add_edge($urandom_range(255), $urandom_range(255), $urandom, k == len - 1);
                else
                    add_edge($urandom_range(lim), $urandom_range(lim),
                             ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom,
                             k == len - 1);
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d batches, %0d edge transfers, %0d results checked.",
                 batch_cnt, accepted_cnt, results_seen);
        $display("Node counts from 0 to 511, lowered count, weight ties, four idle modes.");
        if (mismatch_cnt == 0 && forest_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timed out waiting on the block.");
        $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/kmw_pkg.sv
design/kmw_if.sv
design/kmw_ctrl.sv
design/kmw_datapath.sv
design/kruskal_mst_weight.sv
tb/sv/kruskal_mst_weight_test.sv
